[rtl/core/gpio_pkg.sv]
// gpio register block package: pin count, half-word layout, command and address codes
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package gpio_pkg;

   localparam int PIN_COUNT = 32;
   localparam int HALF_W    = 16;
   localparam int ADDR_W    = 4;
   localparam int CMD_W     = 2;

   // item command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_READ   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_SAMPLE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // register map, address fifteen is unmapped
   typedef enum logic [ADDR_W-1:0] {
      ADDR_INTR_STATE  = 4'd0,
      ADDR_INTR_ENABLE = 4'd1,
      ADDR_INTR_TEST   = 4'd2,
      ADDR_DATA_IN     = 4'd3,
      ADDR_DIRECT_OUT  = 4'd4,
      ADDR_MASK_OUT_LO = 4'd5,
      ADDR_MASK_OUT_HI = 4'd6,
      ADDR_DIRECT_OE   = 4'd7,
      ADDR_MASK_OE_LO  = 4'd8,
      ADDR_MASK_OE_HI  = 4'd9,
      ADDR_RISE_EN     = 4'd10,
      ADDR_FALL_EN     = 4'd11,
      ADDR_HIGH_EN     = 4'd12,
      ADDR_LOW_EN      = 4'd13,
      ADDR_FILTER_EN   = 4'd14
   } addr_type;

   typedef logic [PIN_COUNT-1:0] word_type;

endpackage

`default_nettype wire

[rtl/core/gpio_if.sv]
// request and response channel interfaces of the gpio register block
// depends on gpio_pkg for the payload types
`default_nettype none

interface gpio_req_if;
   import gpio_pkg::*;

   logic     valid;
   logic     ready;
   cmd_type  command;
   addr_type reg_addr;
   word_type write_data;
   word_type pins_in;

   modport source (output valid, output command, output reg_addr,
                   output write_data, output pins_in, input ready);
   modport sink   (input valid, input command, input reg_addr,
                   input write_data, input pins_in, output ready);
endinterface

interface gpio_rsp_if;
   import gpio_pkg::*;

   logic     valid;
   logic     ready;
   word_type read_data;
   word_type pins_out;
   word_type pins_oe;
   word_type irq_lines;

   modport source (output valid, output read_data, output pins_out,
                   output pins_oe, output irq_lines, input ready);
   modport sink   (input valid, input read_data, input pins_out,
                   input pins_oe, input irq_lines, output ready);
endinterface

`default_nettype wire

[rtl/core/gpio_register_block.sv]
// gpio register block top level: bus read/write and pin sample items, one response each
// depends on gpio_pkg and the gpio_req_if / gpio_rsp_if channel interfaces
//
//   channel   direction  payload
//   req       in         command, reg_addr, write_data, pins_in
//   rsp       out        read_data, pins_out, pins_oe, irq_lines
//
// the response becomes valid after the accepting edge: the input register
// holds the item, then the register update and response register load together.
// one item per cycle sustained while rsp is not stalled; the response register
// drains while the next item waits in the input register.
// synchronous reset clears the register file to zero and empties both stages.
// a stalled rsp holds its response and stops the input stage when it is full.
`default_nettype none

module gpio_register_block (
   input  wire         clock,
   input  wire         reset,
   gpio_req_if.sink    req,
   gpio_rsp_if.source  rsp
);
   import gpio_pkg::*;

   // half-word masked update: mask in the high half, data in the low half
   function automatic logic [HALF_W-1:0] masked_half(input logic [HALF_W-1:0] cur,
                                                     input word_type wd);
      logic [HALF_W-1:0] sel;
      sel = wd[PIN_COUNT-1:HALF_W];
      masked_half = (cur & ~sel) | (wd[HALF_W-1:0] & sel);
   endfunction

   // input stage
   logic     s1_valid_ff, s1_valid_in;
   cmd_type  s1_cmd_ff;
   addr_type s1_addr_ff;
   word_type s1_wdata_ff;
   word_type s1_pins_ff;
   logic     s1_go;

   // response stage
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rd_ff, rd_in;

   // register file
   word_type out_ff, out_in;
   word_type oe_ff, oe_in;
   word_type sample_ff, sample_in;
   word_type pending_ff, pending_in;
   word_type irq_en_ff, irq_en_in;
   word_type rise_en_ff, rise_en_in;
   word_type fall_en_ff, fall_en_in;
   word_type high_en_ff, high_en_in;
   word_type low_en_ff, low_en_in;
   word_type filter_en_ff, filter_en_in;

   word_type hits;

   // handshake
   assign s1_go       = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready   = !s1_valid_ff || s1_go;
   assign s1_valid_in = (req.valid && req.ready) ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_go ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   // edge and level triggers against the previous sample
   assign hits = ((s1_pins_ff & ~sample_ff) & rise_en_ff)
               | ((~s1_pins_ff & sample_ff) & fall_en_ff)
               | (s1_pins_ff & high_en_ff)
               | (~s1_pins_ff & low_en_ff);

   // read mux
   always_comb begin
      rd_in = '0;
      if (s1_cmd_ff == CMD_READ) begin
         unique case (s1_addr_ff)
            ADDR_INTR_STATE:  rd_in = pending_ff;
            ADDR_INTR_ENABLE: rd_in = irq_en_ff;
            ADDR_DATA_IN:     rd_in = sample_ff;
            ADDR_DIRECT_OUT:  rd_in = out_ff;
            ADDR_MASK_OUT_LO: rd_in = {{(PIN_COUNT-HALF_W){1'b0}}, out_ff[HALF_W-1:0]};
            ADDR_MASK_OUT_HI: rd_in = {{(PIN_COUNT-HALF_W){1'b0}}, out_ff[PIN_COUNT-1:HALF_W]};
            ADDR_DIRECT_OE:   rd_in = oe_ff;
            ADDR_MASK_OE_LO:  rd_in = {{(PIN_COUNT-HALF_W){1'b0}}, oe_ff[HALF_W-1:0]};
            ADDR_MASK_OE_HI:  rd_in = {{(PIN_COUNT-HALF_W){1'b0}}, oe_ff[PIN_COUNT-1:HALF_W]};
            ADDR_RISE_EN:     rd_in = rise_en_ff;
            ADDR_FALL_EN:     rd_in = fall_en_ff;
            ADDR_HIGH_EN:     rd_in = high_en_ff;
            ADDR_LOW_EN:      rd_in = low_en_ff;
            ADDR_FILTER_EN:   rd_in = filter_en_ff;
            default:          rd_in = '0;
         endcase
      end
   end

   // register updates for writes and sample ticks
   always_comb begin
      out_in       = out_ff;
      oe_in        = oe_ff;
      sample_in    = sample_ff;
      pending_in   = pending_ff;
      irq_en_in    = irq_en_ff;
      rise_en_in   = rise_en_ff;
      fall_en_in   = fall_en_ff;
      high_en_in   = high_en_ff;
      low_en_in    = low_en_ff;
      filter_en_in = filter_en_ff;
      unique case (s1_cmd_ff)
         CMD_WRITE: begin
            unique case (s1_addr_ff)
               ADDR_INTR_STATE:  pending_in = pending_ff & ~s1_wdata_ff;
               ADDR_INTR_ENABLE: irq_en_in = s1_wdata_ff;
               ADDR_INTR_TEST:   pending_in = pending_ff | s1_wdata_ff;
               ADDR_DIRECT_OUT:  out_in = s1_wdata_ff;
               ADDR_MASK_OUT_LO: out_in[HALF_W-1:0] =
                                    masked_half(out_ff[HALF_W-1:0], s1_wdata_ff);
               ADDR_MASK_OUT_HI: out_in[PIN_COUNT-1:HALF_W] =
                                    masked_half(out_ff[PIN_COUNT-1:HALF_W], s1_wdata_ff);
               ADDR_DIRECT_OE:   oe_in = s1_wdata_ff;
               ADDR_MASK_OE_LO:  oe_in[HALF_W-1:0] =
                                    masked_half(oe_ff[HALF_W-1:0], s1_wdata_ff);
               ADDR_MASK_OE_HI:  oe_in[PIN_COUNT-1:HALF_W] =
                                    masked_half(oe_ff[PIN_COUNT-1:HALF_W], s1_wdata_ff);
               ADDR_RISE_EN:     rise_en_in = s1_wdata_ff;
               ADDR_FALL_EN:     fall_en_in = s1_wdata_ff;
               ADDR_HIGH_EN:     high_en_in = s1_wdata_ff;
               ADDR_LOW_EN:      low_en_in = s1_wdata_ff;
               ADDR_FILTER_EN:   filter_en_in = s1_wdata_ff;
               default:          ;
            endcase
         end
         CMD_SAMPLE: begin
            pending_in = pending_ff | hits;
            sample_in  = s1_pins_ff;
         end
         default: ;
      endcase
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req.valid && req.ready) begin
         s1_cmd_ff   <= req.command;
         s1_addr_ff  <= req.reg_addr;
         s1_wdata_ff <= req.write_data;
         s1_pins_ff  <= req.pins_in;
      end
   end

   // register file and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         out_ff       <= '0;
         oe_ff        <= '0;
         sample_ff    <= '0;
         pending_ff   <= '0;
         irq_en_ff    <= '0;
         rise_en_ff   <= '0;
         fall_en_ff   <= '0;
         high_en_ff   <= '0;
         low_en_ff    <= '0;
         filter_en_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (s1_go) begin
            out_ff       <= out_in;
            oe_ff        <= oe_in;
            sample_ff    <= sample_in;
            pending_ff   <= pending_in;
            irq_en_ff    <= irq_en_in;
            rise_en_ff   <= rise_en_in;
            fall_en_ff   <= fall_en_in;
            high_en_ff   <= high_en_in;
            low_en_ff    <= low_en_in;
            filter_en_ff <= filter_en_in;
         end
      end
      if (s1_go) begin
         rd_ff <= rd_in;
      end
   end

   // response outputs, pin and irq views follow the registers after the item
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.read_data = rd_ff;
   assign rsp.pins_out  = out_ff;
   assign rsp.pins_oe   = oe_ff;
   assign rsp.irq_lines = pending_ff & irq_en_ff;

endmodule

`default_nettype wire

[verif/gpio_register_block_tb.sv]
// testbench for gpio_register_block: bus reads, writes and pin samples against a register mirror
// depends on gpio_pkg, gpio_req_if / gpio_rsp_if and the gpio_register_block top level

module gpio_register_block_tb;
   import gpio_pkg::*;

   // the one address the register map leaves unmapped
   localparam logic [ADDR_W-1:0] ADDR_UNMAPPED = 4'd15;
   localparam int ITEM_TARGET = 1200;

   typedef struct packed {
      word_type read_data;
      word_type pins_out;
      word_type pins_oe;
      word_type irq_lines;
   } gpio_rsp_type;

   // shadow copy of the register file and the responses it predicts
   class gpio_mirror;
      word_type out_q, oe_q, pins_q, pending_q, irq_en_q;
      word_type rise_q, fall_q, high_q, low_q, filter_q;
      gpio_rsp_type due_rsp[$];
      int failures;

      function new();
         {out_q, oe_q, pins_q, pending_q, irq_en_q} = '0;
         {rise_q, fall_q, high_q, low_q, filter_q} = '0;
         failures = 0;
      endfunction

      // apply one accepted item and queue the response it should produce
      function void note_item(cmd_type cmd, logic [ADDR_W-1:0] addr, word_type wd,
                              word_type pins);
         gpio_rsp_type exp;
         word_type sel_lo, sel_hi, hits;
         sel_lo = {{HALF_W{1'b0}}, wd[PIN_COUNT-1:HALF_W]};
         sel_hi = {wd[PIN_COUNT-1:HALF_W], {HALF_W{1'b0}}};
         exp.read_data = '0;
         case (cmd)
            CMD_READ: begin
               case (addr)
                  ADDR_INTR_STATE:  exp.read_data = pending_q;
                  ADDR_INTR_ENABLE: exp.read_data = irq_en_q;
                  ADDR_DATA_IN:     exp.read_data = pins_q;
                  ADDR_DIRECT_OUT:  exp.read_data = out_q;
                  ADDR_MASK_OUT_LO: exp.read_data = {{HALF_W{1'b0}}, out_q[HALF_W-1:0]};
                  ADDR_MASK_OUT_HI: exp.read_data = {{HALF_W{1'b0}}, out_q[PIN_COUNT-1:HALF_W]};
                  ADDR_DIRECT_OE:   exp.read_data = oe_q;
                  ADDR_MASK_OE_LO:  exp.read_data = {{HALF_W{1'b0}}, oe_q[HALF_W-1:0]};
                  ADDR_MASK_OE_HI:  exp.read_data = {{HALF_W{1'b0}}, oe_q[PIN_COUNT-1:HALF_W]};
                  ADDR_RISE_EN:     exp.read_data = rise_q;
                  ADDR_FALL_EN:     exp.read_data = fall_q;
                  ADDR_HIGH_EN:     exp.read_data = high_q;
                  ADDR_LOW_EN:      exp.read_data = low_q;
                  ADDR_FILTER_EN:   exp.read_data = filter_q;
                  default:          exp.read_data = '0;
               endcase
            end
            CMD_WRITE: begin
               case (addr)
                  ADDR_INTR_STATE:  pending_q = pending_q & ~wd;
                  ADDR_INTR_ENABLE: irq_en_q = wd;
                  ADDR_INTR_TEST:   pending_q = pending_q | wd;
                  ADDR_DIRECT_OUT:  out_q = wd;
                  ADDR_MASK_OUT_LO: out_q = (out_q & ~sel_lo) | (wd & sel_lo);
                  ADDR_MASK_OUT_HI: out_q = (out_q & ~sel_hi)
                                          | ({wd[HALF_W-1:0], {HALF_W{1'b0}}} & sel_hi);
                  ADDR_DIRECT_OE:   oe_q = wd;
                  ADDR_MASK_OE_LO:  oe_q = (oe_q & ~sel_lo) | (wd & sel_lo);
                  ADDR_MASK_OE_HI:  oe_q = (oe_q & ~sel_hi)
                                         | ({wd[HALF_W-1:0], {HALF_W{1'b0}}} & sel_hi);
                  ADDR_RISE_EN:     rise_q = wd;
                  ADDR_FALL_EN:     fall_q = wd;
                  ADDR_HIGH_EN:     high_q = wd;
                  ADDR_LOW_EN:      low_q = wd;
                  ADDR_FILTER_EN:   filter_q = wd;
                  default: ;
               endcase
            end
            CMD_SAMPLE: begin
               // edges are taken against the previous sample, zero after reset
               hits = (pins & ~pins_q & rise_q) | (~pins & pins_q & fall_q)
                    | (pins & high_q) | (~pins & low_q);
               pending_q = pending_q | hits;
               pins_q = pins;
            end
            default: ;
         endcase
         exp.pins_out  = out_q;
         exp.pins_oe   = oe_q;
         exp.irq_lines = pending_q & irq_en_q;
         due_rsp.push_back(exp);
      endfunction

      // compare one accepted response with the oldest prediction
      function void check_response(word_type rd, word_type po, word_type oe, word_type irq);
         gpio_rsp_type exp;
         if (due_rsp.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected response: rd %h out %h oe %h irq %h", rd, po, oe, irq);
            return;
         end
         exp = due_rsp.pop_front();
         if (rd !== exp.read_data || po !== exp.pins_out || oe !== exp.pins_oe
             || irq !== exp.irq_lines) begin
            failures++;
            if (failures <= 10)
               $display({"mismatch at %0t: exp rd %h out %h oe %h irq %h,",
                         " got rd %h out %h oe %h irq %h"},
                        $realtime, exp.read_data, exp.pins_out, exp.pins_oe, exp.irq_lines,
                        rd, po, oe, irq);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   gpio_req_if req_ch ();
   gpio_rsp_if rsp_ch ();

   gpio_register_block dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   gpio_mirror mirror = new();
   word_type   last_pins = '0;
   logic [15:0] stall_bits = '1;
   int          stall_epoch = 0;

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watch both channels; the input side goes first so a same-edge response still finds it
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            mirror.note_item(req_ch.command, req_ch.reg_addr, req_ch.write_data, req_ch.pins_in);
         if (rsp_ch.valid && rsp_ch.ready)
            mirror.check_response(rsp_ch.read_data, rsp_ch.pins_out, rsp_ch.pins_oe,
                                  rsp_ch.irq_lines);
      end
   end

   // response backpressure: a rotating stall pattern, reloaded every epoch
   always @(posedge clock) begin
      if (stall_epoch == 0) begin
         case ($urandom_range(0, 3))
            0:       stall_bits <= '1;
            1:       stall_bits <= 16'($urandom) | 16'h0101;
            2:       stall_bits <= 16'hFF00;
            default: stall_bits <= 16'b1011_0111_0111_1011;
         endcase
         stall_epoch <= $urandom_range(32, 200);
      end else begin
         stall_bits  <= {stall_bits[0], stall_bits[15:1]};
         stall_epoch <= stall_epoch - 1;
      end
      rsp_ch.ready <= stall_bits[0];
   end

   // present one item and hold it until the block takes it
   task automatic send_item(cmd_type cmd, logic [ADDR_W-1:0] addr, word_type wd,
                            word_type pins);
      req_ch.valid      <= 1'b1;
      req_ch.command    <= cmd;
      req_ch.reg_addr   <= addr_type'(addr);
      req_ch.write_data <= wd;
      req_ch.pins_in    <= pins;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // data word with a bias toward corner patterns
   function automatic word_type pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return word_type'(1) << $urandom_range(0, PIN_COUNT - 1);
         3:       return $urandom & $urandom;
         4:       return $urandom | $urandom;
         default: return $urandom;
      endcase
   endfunction

   // random item: mostly reads and writes, pin samples that usually toggle a few pins
   task automatic random_item(output cmd_type cmd, output logic [ADDR_W-1:0] addr,
                              output word_type wd, output word_type pins);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 35)      cmd = CMD_READ;
      else if (roll < 70) cmd = CMD_WRITE;
      else if (roll < 96) cmd = CMD_SAMPLE;
      else                cmd = CMD_NONE;
      addr = ADDR_W'($urandom_range(0, 15));
      wd   = pick_word();
      case ($urandom_range(0, 5))
         0:       pins = pick_word();
         1:       pins = ~last_pins;
         default: pins = last_pins ^ ($urandom & $urandom & $urandom);
      endcase
   endtask

   // stimulus
   initial begin
      cmd_type          cmd;
      logic [ADDR_W-1:0] addr;
      word_type         wd, pins;
      int               sent, drain;

      req_ch.valid      <= 1'b0;
      req_ch.command    <= CMD_READ;
      req_ch.reg_addr   <= ADDR_INTR_STATE;
      req_ch.write_data <= '0;
      req_ch.pins_in    <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: first sample against zero, clear and test of interrupt state
      send_item(CMD_WRITE,  ADDR_RISE_EN,     '1, $urandom);
      send_item(CMD_WRITE,  ADDR_INTR_ENABLE, '1, $urandom);
      send_item(CMD_SAMPLE, ADDR_INTR_STATE,  $urandom, 32'hA5A5_F00F);
      send_item(CMD_READ,   ADDR_INTR_STATE,  $urandom, $urandom);
      send_item(CMD_WRITE,  ADDR_INTR_STATE,  32'h0000_FFFF, $urandom);
      send_item(CMD_WRITE,  ADDR_INTR_TEST,   32'h8000_0001, $urandom);
      send_item(CMD_READ,   ADDR_INTR_TEST,   $urandom, $urandom);
      // data in is read only
      send_item(CMD_WRITE,  ADDR_DATA_IN,     '1, $urandom);
      send_item(CMD_READ,   ADDR_DATA_IN,     $urandom, $urandom);
      // direct and masked output writes, masked reads
      send_item(CMD_WRITE,  ADDR_DIRECT_OUT,  '1, $urandom);
      send_item(CMD_WRITE,  ADDR_MASK_OUT_LO, 32'h00FF_0000, $urandom);
      send_item(CMD_WRITE,  ADDR_MASK_OUT_HI, 32'hF0F0_0A0A, $urandom);
      send_item(CMD_READ,   ADDR_MASK_OUT_LO, $urandom, $urandom);
      send_item(CMD_READ,   ADDR_MASK_OUT_HI, $urandom, $urandom);
      send_item(CMD_WRITE,  ADDR_DIRECT_OE,   '0, $urandom);
      send_item(CMD_WRITE,  ADDR_MASK_OE_LO,  '1, $urandom);
      send_item(CMD_WRITE,  ADDR_MASK_OE_HI,  32'h8001_FFFF, $urandom);
      send_item(CMD_READ,   ADDR_MASK_OE_HI,  $urandom, $urandom);
      // falling and level triggers on an all-low sample
      send_item(CMD_WRITE,  ADDR_FALL_EN,     32'h0000_FFFF, $urandom);
      send_item(CMD_WRITE,  ADDR_HIGH_EN,     32'h00FF_0000, $urandom);
      send_item(CMD_WRITE,  ADDR_LOW_EN,      32'hFF00_0000, $urandom);
      send_item(CMD_WRITE,  ADDR_FILTER_EN,   '1, $urandom);
      send_item(CMD_SAMPLE, ADDR_INTR_STATE,  $urandom, '0);
      send_item(CMD_READ,   ADDR_FILTER_EN,   $urandom, $urandom);
      // unmapped address and the unused command
      send_item(CMD_WRITE,  ADDR_UNMAPPED,    '1, $urandom);
      send_item(CMD_READ,   ADDR_UNMAPPED,    $urandom, $urandom);
      send_item(CMD_NONE,   ADDR_DIRECT_OUT,  '1, '1);

      // random bursts with gaps, some bursts running straight into the next
      sent = 0;
      while (sent < ITEM_TARGET) begin
         repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 16)) begin
            random_item(cmd, addr, wd, pins);
            send_item(cmd, addr, wd, pins);
            if (cmd == CMD_SAMPLE) last_pins = pins;
            if (cmd != CMD_NONE) sent++;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      req_ch.valid <= 1'b0;

      // drain outstanding responses, then let the pipeline settle
      drain = 0;
      while (mirror.due_rsp.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);

      if (mirror.failures == 0 && mirror.due_rsp.size() == 0)
         $display("** gpio_register_block: PASSED **");
      else
         $display("** gpio_register_block: FAILED **");
      $finish;
   end

   // hang guard
   initial begin
      #2000000;
      $display("** gpio_register_block: FAILED **");
      $finish;
   end

endmodule
